>>> sv/integer_literal_parser_top_assert.svh
// Assertion macros shared by the parser modules.
// Each macro samples on aclk and is switched off while aresetn is low.
`ifndef INTEGER_LITERAL_PARSER_TOP_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ILP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ILP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ilp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilp_pkg;

    // Character classes seen by the scanner
    typedef enum logic [2:0] {
        KIND_SPACE,
        KIND_MINUS,
        KIND_ZERO,
        KIND_DIGIT,
        KIND_LETX,
        KIND_HEXL,
        KIND_OTHER
    } char_kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SYN  = 2'd1,
        STATUS_UOVF = 2'd2,
        STATUS_SOVF = 2'd3
    } status_t;

    // One classified character as it travels from front to back
    typedef struct packed {
        char_kind_t  kind;
        logic [3:0]  digit;
        logic        last;
    } char_item_t;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWX  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWF  = 8'h66;

endpackage

`default_nettype wire

>>> sv/ilp_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module ilp_classify (
    input  wire logic [ilp_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       last_char,
    output ilp_pkg::char_item_t             item
);

    // Sort the character into its scanner class and extract its digit value
    always_comb begin
        item.last  = last_char;
        item.digit = char_code[ilp_pkg::DIGIT_W-1:0];
        if (char_code == ilp_pkg::CH_SPACE) begin
            item.kind = ilp_pkg::KIND_SPACE;
        end else if (char_code == ilp_pkg::CH_MINUS) begin
            item.kind = ilp_pkg::KIND_MINUS;
        end else if (char_code == ilp_pkg::CH_ZERO) begin
            item.kind = ilp_pkg::KIND_ZERO;
        end else if (char_code > ilp_pkg::CH_ZERO && char_code <= ilp_pkg::CH_NINE) begin
            item.kind = ilp_pkg::KIND_DIGIT;
        end else if (char_code == ilp_pkg::CH_LOWX) begin
            item.kind = ilp_pkg::KIND_LETX;
        end else if (char_code >= ilp_pkg::CH_LOWA && char_code <= ilp_pkg::CH_LOWF) begin
            // 'a' has low nibble 1, so add nine to reach ten
            item.kind  = ilp_pkg::KIND_HEXL;
            item.digit = char_code[ilp_pkg::DIGIT_W-1:0] + 4'd9;
        end else begin
            item.kind = ilp_pkg::KIND_OTHER;
        end
    end

endmodule

`default_nettype wire

>>> sv/ilp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ilp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ilp_pkg::char_item_t in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ilp_pkg::char_item_t      out_item
);

`include "integer_literal_parser_top_assert.svh"

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ilp_pkg::char_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the request into its slot
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    `ILP_ASSERT_IMP(a_cnt_bound, 1'b1, count_reg <= CNT_FULL, "queue count beyond depth")
    `ILP_ASSERT_IMP(a_ptr_agree, count_reg == '0 || count_reg == CNT_FULL, wr_ptr_reg == rd_ptr_reg, "pointers disagree with count")
    `ILP_ASSERT_NXT(a_cnt_step, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule

`default_nettype wire

>>> sv/ilp_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module ilp_exec (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire ilp_pkg::char_item_t          in_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ilp_pkg::VALUE_W-1:0]       out_value,
    output ilp_pkg::status_t                  out_status
);

`include "integer_literal_parser_top_assert.svh"

    localparam int unsigned WIDE_W = ilp_pkg::VALUE_W + 4;

    typedef enum logic [2:0] {
        ST_START,
        ST_ZERO,
        ST_DEC,
        ST_MINUS,
        ST_HEX0,
        ST_HEX,
        ST_FAIL
    } scan_state_t;

    scan_state_t                  state_reg, state_next;
    logic [ilp_pkg::VALUE_W-1:0]  mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    ilp_pkg::status_t             err_reg, err_next;

    logic                         out_valid_reg, out_valid_next;
    logic [ilp_pkg::VALUE_W-1:0]  out_mag_reg, out_mag_next;
    logic                         out_neg_reg, out_neg_next;
    ilp_pkg::status_t             out_status_reg, out_status_next;

    logic                         pop;
    logic                         is_dec;
    logic [WIDE_W-1:0]            mag_wide;
    logic [WIDE_W-1:0]            dec_wide;
    logic                         dec_ovf;
    logic                         hex_ovf;
    logic                         res_ok;
    ilp_pkg::status_t             res_status;

    // A character that ends a literal needs a free output register
    assign in_ready = !in_item.last || !out_valid_reg || out_ready;
    assign pop      = in_valid && in_ready;

    // Decimal step: ten times the magnitude plus the digit, overflow in the top nibble
    assign is_dec   = (in_item.kind == ilp_pkg::KIND_ZERO) ||
                      (in_item.kind == ilp_pkg::KIND_DIGIT);
    assign mag_wide = {4'b0, mag_reg};
    assign dec_wide = (mag_wide << 3) + (mag_wide << 1) +
                      {{(WIDE_W - ilp_pkg::DIGIT_W){1'b0}}, in_item.digit};
    assign dec_ovf  = |dec_wide[WIDE_W-1:ilp_pkg::VALUE_W];
    assign hex_ovf  = |mag_reg[ilp_pkg::VALUE_W-1:ilp_pkg::VALUE_W-4];

    // Scanner transition for the popped character
    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_START: begin
                case (in_item.kind)
                    ilp_pkg::KIND_SPACE: begin
                    end
                    ilp_pkg::KIND_MINUS: begin
                        neg_next   = 1'b1;
                        state_next = ST_MINUS;
                    end
                    ilp_pkg::KIND_ZERO: begin
                        mag_next   = '0;
                        state_next = ST_ZERO;
                    end
                    ilp_pkg::KIND_DIGIT: begin
                        mag_next   = {{(ilp_pkg::VALUE_W - ilp_pkg::DIGIT_W){1'b0}},
                                      in_item.digit};
                        state_next = ST_DEC;
                    end
                    default: begin
                        state_next = ST_FAIL;
                        err_next   = ilp_pkg::STATUS_SYN;
                    end
                endcase
            end
            ST_MINUS: begin
                case (in_item.kind)
                    ilp_pkg::KIND_ZERO: begin
                        mag_next   = '0;
                        state_next = ST_ZERO;
                    end
                    ilp_pkg::KIND_DIGIT: begin
                        mag_next   = {{(ilp_pkg::VALUE_W - ilp_pkg::DIGIT_W){1'b0}},
                                      in_item.digit};
                        state_next = ST_DEC;
                    end
                    default: begin
                        state_next = ST_FAIL;
                        err_next   = ilp_pkg::STATUS_SYN;
                    end
                endcase
            end
            ST_ZERO, ST_DEC: begin
                if (is_dec) begin
                    if (dec_ovf) begin
                        state_next = ST_FAIL;
                        err_next   = ilp_pkg::STATUS_UOVF;
                    end else begin
                        mag_next   = dec_wide[ilp_pkg::VALUE_W-1:0];
                        state_next = ST_DEC;
                    end
                end else if (state_reg == ST_ZERO && in_item.kind == ilp_pkg::KIND_LETX) begin
                    state_next = ST_HEX0;
                end else begin
                    state_next = ST_FAIL;
                    err_next   = ilp_pkg::STATUS_SYN;
                end
            end
            ST_HEX0, ST_HEX: begin
                if (is_dec || in_item.kind == ilp_pkg::KIND_HEXL) begin
                    if (hex_ovf) begin
                        state_next = ST_FAIL;
                        err_next   = ilp_pkg::STATUS_UOVF;
                    end else begin
                        mag_next   = {mag_reg[ilp_pkg::VALUE_W-5:0], in_item.digit};
                        state_next = ST_HEX;
                    end
                end else begin
                    state_next = ST_FAIL;
                    err_next   = ilp_pkg::STATUS_SYN;
                end
            end
            default: begin
            end
        endcase
    end

    // Status of a literal that ends with this character
    always_comb begin
        if (state_next == ST_FAIL) begin
            res_status = err_next;
        end else if (neg_next && mag_next[ilp_pkg::VALUE_W-1]) begin
            res_status = ilp_pkg::STATUS_SOVF;
        end else begin
            res_status = ilp_pkg::STATUS_OK;
        end
        res_ok = (res_status == ilp_pkg::STATUS_OK);
    end

    // Load the output register on a final character, drop it once taken
    always_comb begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_mag_next    = out_mag_reg;
        out_neg_next    = out_neg_reg;
        out_status_next = out_status_reg;
        if (pop && in_item.last) begin
            out_valid_next  = 1'b1;
            out_mag_next    = res_ok ? mag_next : '0;
            out_neg_next    = res_ok && neg_next;
            out_status_next = res_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_START;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            err_reg       <= ilp_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                if (in_item.last) begin
                    state_reg <= ST_START;
                    mag_reg   <= '0;
                    neg_reg   <= 1'b0;
                    err_reg   <= ilp_pkg::STATUS_OK;
                end else begin
                    state_reg <= state_next;
                    mag_reg   <= mag_next;
                    neg_reg   <= neg_next;
                    err_reg   <= err_next;
                end
            end
        end
        out_mag_reg    <= out_mag_next;
        out_neg_reg    <= out_neg_next;
        out_status_reg <= out_status_next;
    end

    // Negate on the way out
    assign out_valid  = out_valid_reg;
    assign out_value  = out_neg_reg ? (ilp_pkg::VALUE_W'(0) - out_mag_reg) : out_mag_reg;
    assign out_status = out_status_reg;

    `ILP_ASSERT_IMP(a_fail_err, state_reg == ST_FAIL, err_reg != ilp_pkg::STATUS_OK, "failed without error code")
    `ILP_ASSERT_IMP(a_start_clear, state_reg == ST_START, mag_reg == '0 && !neg_reg, "start state holds stale data")
    `ILP_ASSERT_IMP(a_err_zero, out_valid_reg && out_status_reg != ilp_pkg::STATUS_OK, out_mag_reg == '0 && !out_neg_reg, "error result carries a value")
    `ILP_ASSERT_NXT(a_last_reset, pop && in_item.last, state_reg == ST_START && out_valid_reg, "final character did not restart scan")

endmodule

`default_nettype wire

>>> sv/integer_literal_parser_top.sv
// Channel  Dir  Bus fields (low bit up)             Meaning
// s_       in   tdata: char_code[7:0]; tlast        one literal character, last of literal
// m_       out  tdata: value[63:0], status[65:64]   parsed value and status, one per literal
//
// One character per cycle while s_tready is high; the scanner step (multiply by ten, add,
// compare) is combinational. m_tvalid rises once the final character, written into the
// queue, has been run through the scanner into the output register.
// Reset is synchronous (aresetn low) and returns the scanner to its start state at once.
// A waiting result holds the next final character at the queue head; s_tready falls once
// QUEUE_DEPTH characters, that one included, are queued.
`timescale 1ns / 1ps
`default_nettype none

module integer_literal_parser_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [63:0] value, [65:64] status, [71:66] zero
);

    ilp_pkg::char_item_t              front_item;
    ilp_pkg::char_item_t              back_item;
    logic                             back_valid;
    logic                             back_ready;
    logic [ilp_pkg::VALUE_W-1:0]      res_value;
    ilp_pkg::status_t                 res_status;

    // Classify each incoming character
    ilp_classify u_classify (
        .char_code (s_tdata),
        .last_char (s_tlast),
        .item      (front_item)
    );

    // Decouple the classifier from the scanner
    ilp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    // Run the scanner and hold the result
    ilp_exec u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (back_valid),
        .in_ready   (back_ready),
        .in_item    (back_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (res_value),
        .out_status (res_status)
    );

    assign m_tdata = {6'b0, res_status, res_value};

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    // Scanner states of the predictor
    typedef enum logic [2:0] {
        LX_IDLE,
        LX_LEAD_ZERO,
        LX_DECIMAL,
        LX_SIGN,
        LX_HEX_PREFIX,
        LX_HEX,
        LX_DEAD
    } lex_state_t;

    typedef struct {
        logic [63:0]      value;
        ilp_pkg::status_t status;
    } parse_result_t;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_AT        = 1000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned REPORT_MAX     = 10;

    // Predicts parsed literals from accepted characters and checks the results
    class literal_scoreboard;
        lex_state_t       lex;
        logic [63:0]      mag;
        logic             neg;
        ilp_pkg::status_t err;
        parse_result_t    pending_results[$];
        int unsigned      chars_seen;
        int unsigned      literals_checked;
        int unsigned      errors;
        int unsigned      by_status[4];

        function new();
            restart();
            chars_seen = 0;
            literals_checked = 0;
            errors = 0;
            foreach (by_status[i]) by_status[i] = 0;
        endfunction

        function void restart();
            lex = LX_IDLE;
            mag = '0;
            neg = 1'b0;
            err = ilp_pkg::STATUS_OK;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= REPORT_MAX) $display("MISMATCH: %s", what);
        endfunction

        function void kill(ilp_pkg::status_t kind);
            lex = LX_DEAD;
            err = kind;
        endfunction

        // Advance the scanner by one character
        function void scan(logic [7:0] c);
            logic       is_dec;
            logic       is_hexl;
            logic [7:0] dv;
            logic [7:0] hv;
            is_dec  = (c >= ilp_pkg::CH_ZERO) && (c <= ilp_pkg::CH_NINE);
            is_hexl = (c >= ilp_pkg::CH_LOWA) && (c <= ilp_pkg::CH_LOWF);
            dv = is_dec ? c - ilp_pkg::CH_ZERO : 8'd0;
            hv = is_dec ? dv : (is_hexl ? c - ilp_pkg::CH_LOWA + 8'd10 : 8'd0);
            case (lex)
                LX_IDLE, LX_SIGN: begin
                    if (lex == LX_IDLE && c == ilp_pkg::CH_SPACE) begin
                        // leading spaces are skipped
                    end else if (lex == LX_IDLE && c == ilp_pkg::CH_MINUS) begin
                        neg = 1'b1;
                        lex = LX_SIGN;
                    end else if (c == ilp_pkg::CH_ZERO) begin
                        mag = '0;
                        lex = LX_LEAD_ZERO;
                    end else if (is_dec) begin
                        mag = {56'd0, dv};
                        lex = LX_DECIMAL;
                    end else begin
                        kill(ilp_pkg::STATUS_SYN);
                    end
                end
                LX_LEAD_ZERO, LX_DECIMAL: begin
                    if (is_dec) begin
                        // exact overflow test before multiply-accumulate
                        if (mag > (64'hFFFF_FFFF_FFFF_FFFF - {56'd0, dv}) / 64'd10) begin
                            kill(ilp_pkg::STATUS_UOVF);
                        end else begin
                            mag = mag * 64'd10 + {56'd0, dv};
                            lex = LX_DECIMAL;
                        end
                    end else if (lex == LX_LEAD_ZERO && c == ilp_pkg::CH_LOWX) begin
                        lex = LX_HEX_PREFIX;
                    end else begin
                        kill(ilp_pkg::STATUS_SYN);
                    end
                end
                LX_HEX_PREFIX, LX_HEX: begin
                    if (is_dec || is_hexl) begin
                        if (mag[63:60] != 4'd0) begin
                            kill(ilp_pkg::STATUS_UOVF);
                        end else begin
                            mag = {mag[59:0], hv[3:0]};
                            lex = LX_HEX;
                        end
                    end else begin
                        kill(ilp_pkg::STATUS_SYN);
                    end
                end
                default: begin
                    // dead: ignore everything until the last character
                end
            endcase
        endfunction

        // Note one accepted character request
        function void note_char(logic [7:0] c, logic last);
            parse_result_t r;
            chars_seen++;
            scan(c);
            if (last) begin
                r.value  = '0;
                r.status = ilp_pkg::STATUS_OK;
                if (lex == LX_DEAD) begin
                    r.status = err;
                end else if (neg) begin
                    if (mag[63]) r.status = ilp_pkg::STATUS_SOVF;
                    else r.value = 64'd0 - mag;
                end else begin
                    r.value = mag;
                end
                pending_results.push_back(r);
                by_status[r.status]++;
                restart();
            end
        endfunction

        // Check one accepted result request against the oldest prediction
        function void check_result(logic [71:0] beat);
            parse_result_t want;
            if (pending_results.size() == 0) begin
                flag($sformatf("result %h arrived with nothing predicted", beat));
                return;
            end
            want = pending_results.pop_front();
            if (beat[63:0] !== want.value)
                flag($sformatf("literal %0d value: expected %h, got %h",
                               literals_checked, want.value, beat[63:0]));
            if (beat[65:64] !== want.status)
                flag($sformatf("literal %0d status: expected %0d, got %0d",
                               literals_checked, want.status, beat[65:64]));
            if (beat[71:66] !== 6'd0)
                flag($sformatf("literal %0d padding: expected 0, got %h",
                               literals_checked, beat[71:66]));
            literals_checked++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    literal_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned idle_cycles = 0;
    bit          hold_done;
    byte unsigned lit_buf[$];

    integer_literal_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watch both channels and the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog: no request moved for %0d cycles", idle_cycles);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // Result sink: random back-pressure plus one long hold-off
    initial begin : sink
        int unsigned held;
        m_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && sb.chars_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function void push_text(string s);
        for (int i = 0; i < s.len(); i++) lit_buf.push_back(s[i]);
    endfunction

    // Build one random literal into the buffer
    function void build_random_literal();
        string       hexd;
        int unsigned kind;
        int unsigned pick;
        logic [63:0] m;
        hexd = "0123456789abcdef";
        kind = $urandom_range(99);
        lit_buf.delete();
        if (kind < 70 || kind >= 90) begin
            // well-formed literal, possibly broken afterwards
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3)) push_text(" ");
            if ($urandom_range(9) < 3) push_text("-");
            pick = $urandom_range(5);
            case (pick)
                0: m = 64'($urandom_range(999));
                1: m = {32'd0, $urandom()};
                2: m = {$urandom(), $urandom()};
                3: m = 64'h7FFF_FFFF_FFFF_FFFF;
                4: m = 64'h8000_0000_0000_0000;
                default: m = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            if ($urandom_range(1) == 0) begin
                repeat ($urandom_range(0, 2)) push_text("0");
                push_text($sformatf("%0d", m));
            end else begin
                push_text("0x");
                repeat ($urandom_range(0, 2)) push_text("0");
                push_text($sformatf("%0h", m));
            end
            if (kind >= 90) begin
                if ($urandom_range(1) == 0) begin
                    lit_buf[$urandom_range(lit_buf.size() - 1)] = 8'($urandom_range(255));
                end else begin
                    lit_buf.delete();
                    repeat ($urandom_range(1, 6)) lit_buf.push_back(8'($urandom_range(255)));
                end
            end
        end else if (kind < 80) begin
            // literals near or past the 64-bit limit
            pick = $urandom_range(3);
            if (pick == 0) begin
                push_text("18446744073709551616");
            end else if (pick == 1) begin
                push_text("0x1");
                repeat (16) lit_buf.push_back(hexd[$urandom_range(15)]);
            end else begin
                lit_buf.push_back(8'(ilp_pkg::CH_ZERO + $urandom_range(1, 9)));
                repeat ($urandom_range(18, 21))
                    lit_buf.push_back(8'(ilp_pkg::CH_ZERO + $urandom_range(9)));
            end
            if ($urandom_range(3) == 0) lit_buf.push_front(ilp_pkg::CH_MINUS);
        end else begin
            // incomplete literals
            pick = $urandom_range(4);
            case (pick)
                0: push_text("  ");
                1: push_text("-");
                2: push_text("0x");
                3: push_text("-0x");
                default: push_text(" -");
            endcase
        end
    endfunction

    // Offer one character request and hold it until taken
    task automatic send_item(input logic [7:0] c, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_literal();
        for (int i = 0; i < lit_buf.size(); i++)
            send_item(lit_buf[i], i == lit_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        lit_buf.delete();
        push_text(s);
        send_literal();
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : stimulus
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 51;
        items_sent  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 24; recv_idle_pct = 51; end
                1: begin send_idle_pct = 51; recv_idle_pct = 24; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (phase == 0) begin
                // directed: hex with sign, leading zeros, incomplete forms, bad codes
                send_text("-0x1f");
                send_text("007");
                send_text(" ");
                send_text("-");
                send_text("0x");
                send_text("12a");
                send_text("-a5");
                send_text("0xF");
                lit_buf = '{8'hFF};
                send_literal();
                lit_buf = '{8'h00};
                send_literal();
            end
            while (items_sent < 440 * (phase + 1) - (phase == 2 ? 20 : 0)) begin
                build_random_literal();
                send_literal();
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.flag($sformatf("%0d predicted results never arrived", sb.pending()));
        $display("Run covered %0d characters and %0d literals, with one long output hold-off",
                 items_sent, sb.literals_checked);
        $display("Status mix: ok %0d, syntax %0d, unsigned overflow %0d, signed overflow %0d",
                 sb.by_status[ilp_pkg::STATUS_OK], sb.by_status[ilp_pkg::STATUS_SYN],
                 sb.by_status[ilp_pkg::STATUS_UOVF], sb.by_status[ilp_pkg::STATUS_SOVF]);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/ilp_pkg.sv
sv/ilp_classify.sv
sv/ilp_queue.sv
sv/ilp_exec.sv
sv/integer_literal_parser_top.sv
bench/tb.sv
